>>> rtl/fpda_pkg.sv
package fpda_pkg;

	localparam int IN_W   = 48;
	localparam int CHAR_W = 8;
	localparam int CFG_W  = 4;

	localparam int DEF_INT_DIGITS      = 10;
	localparam int DEF_FRAC_BITS       = 16;
	localparam int DEF_MAX_FRAC_DIGITS = 8;

	localparam logic [CFG_W-1:0] FRAC_DIGITS_RST = 4'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef logic [3:0] bcd_digit_t;

endpackage

>>> rtl/fixed_point_to_decimal_ascii_unit.sv
// Channel   Signals                               Role
// input     in_valid, in_ready, value_fixed       one signed number per transaction
// output    out_valid, out_ready, char_code,      one ASCII character per transaction,
//           last_char                             last_char marks the end of the text
// config    cfg_we, cfg_wdata                     frac_digits, reset value 2
//
// One number at a time. After acceptance the integer part goes through a
// bit-serial binary to BCD converter. The characters are then sent in order:
// a minus sign for a negative number, the integer digits with leading zeros
// suppressed, the point, then the frac digits. The character register lets the
// next character be prepared while one waits; a held character that is not
// taken (out_ready low) stalls the sequencer.
// arst_n clears all control state and sets frac_digits to 2.
module fixed_point_to_decimal_ascii_unit import fpda_pkg::*; #(
	parameter int INT_DIGITS      = DEF_INT_DIGITS,
	parameter int FRAC_BITS       = DEF_FRAC_BITS,
	parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_W-1:0]   value_fixed,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CHAR_W-1:0]        char_code,
	output logic                     last_char,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_wdata
);

	localparam int IPW = IN_W - FRAC_BITS;
	localparam int IW  = $clog2(INT_DIGITS + 1);
	localparam int FDW = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int DW  = INT_DIGITS * 4;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_SIGN  = 3'd2;
	localparam logic [2:0] S_INT   = 3'd3;
	localparam logic [2:0] S_POINT = 3'd4;
	localparam logic [2:0] S_FRAC  = 3'd5;

	logic [2:0]             state_q;
	logic [CFG_W-1:0]       frac_digits_q;
	logic [FDW-1:0]         nfrac_q;
	logic [FDW-1:0]         fcnt_q;
	logic [IW-1:0]          icnt_q;
	logic                   neg_q;
	logic                   sat_q;
	logic                   started_q;
	logic [FRAC_BITS-1:0]   frac_q;
	logic [DW-1:0]          idig_q;
	logic                   ov_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   accept;
	logic [IN_W-1:0]        raw;
	logic [IN_W-1:0]        mag;
	logic [FDW-1:0]         nfrac;
	logic                   cv_done;
	logic                   cv_ovf;
	logic [DW-1:0]          cv_digits;
	logic                   slot;
	bcd_digit_t             top_d;
	logic                   skip;
	logic [FRAC_BITS+3:0]   prod;
	logic                   emit;
	logic [CHAR_W-1:0]      emit_char;
	logic                   emit_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign raw      = value_fixed;
	assign mag      = raw[IN_W-1] ? (~raw + IN_W'(1)) : raw;
	assign nfrac    = (32'(frac_digits_q) > MAX_FRAC_DIGITS) ? FDW'(MAX_FRAC_DIGITS)
	                                                         : FDW'(frac_digits_q);

	fpda_bin2bcd #(
		.IPW        (IPW),
		.INT_DIGITS (INT_DIGITS)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.bin    (mag[IN_W-1:FRAC_BITS]),
		.done   (cv_done),
		.ovf    (cv_ovf),
		.digits (cv_digits)
	);

	assign slot  = !ov_q || out_ready;
	assign top_d = idig_q[DW-1 -: 4];
	assign skip  = !sat_q && !started_q && (top_d == 4'd0) && (icnt_q != IW'(1));
	assign prod  = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			S_SIGN: begin
				emit      = 1'b1;
				emit_char = CH_MINUS;
			end
			S_INT: begin
				emit      = !skip;
				emit_char = sat_q ? CH_NINE : CH_ZERO + {4'b0000, top_d};
			end
			S_POINT: begin
				emit      = 1'b1;
				emit_char = CH_POINT;
				emit_last = (nfrac_q == '0);
			end
			S_FRAC: begin
				emit      = 1'b1;
				emit_char = CH_ZERO + {4'b0000, prod[FRAC_BITS+3:FRAC_BITS]};
				emit_last = (fcnt_q == nfrac_q - FDW'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q <= FRAC_DIGITS_RST;
		end else if (cfg_we) begin
			frac_digits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ov_q      <= 1'b0;
			icnt_q    <= '0;
			fcnt_q    <= '0;
			started_q <= 1'b0;
		end else begin
			if (emit && slot) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (cv_done) begin
						icnt_q    <= IW'(INT_DIGITS);
						started_q <= 1'b0;
						state_q   <= neg_q ? S_SIGN : S_INT;
					end
				end
				S_SIGN: begin
					if (slot) begin
						state_q <= S_INT;
					end
				end
				S_INT: begin
					if (skip) begin
						icnt_q <= icnt_q - IW'(1);
					end else if (slot) begin
						icnt_q    <= icnt_q - IW'(1);
						started_q <= 1'b1;
						if (icnt_q == IW'(1)) begin
							state_q <= S_POINT;
						end
					end
				end
				S_POINT: begin
					if (slot) begin
						fcnt_q  <= '0;
						state_q <= (nfrac_q == '0) ? S_IDLE : S_FRAC;
					end
				end
				S_FRAC: begin
					if (slot) begin
						fcnt_q <= fcnt_q + FDW'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= raw[IN_W-1];
			frac_q  <= mag[FRAC_BITS-1:0];
			nfrac_q <= nfrac;
		end
		if (state_q == S_CONV && cv_done) begin
			idig_q <= cv_digits;
			sat_q  <= cv_ovf;
		end
		if (state_q == S_INT && (skip || slot)) begin
			idig_q <= idig_q << 4;
		end
		if (state_q == S_FRAC && slot) begin
			frac_q <= prod[FRAC_BITS-1:0];
		end
		if (emit && slot) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = ov_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

>>> rtl/fpda_bin2bcd.sv
module fpda_bin2bcd import fpda_pkg::*; #(
	parameter int IPW        = IN_W - DEF_FRAC_BITS,
	parameter int INT_DIGITS = DEF_INT_DIGITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [IPW-1:0]            bin,
	output logic                      done,
	output logic                      ovf,
	output logic [INT_DIGITS*4-1:0]   digits
);

	localparam int NBCD = (IPW * 3) / 10 + 1;
	localparam int ND   = (NBCD > INT_DIGITS) ? NBCD : INT_DIGITS;
	localparam int CW   = $clog2(IPW + 1);

	logic [IPW-1:0]  sh_q;
	logic [ND*4-1:0] bcd_q;
	logic [ND*4-1:0] adj;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			bcd_digit_t d;
			d = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(IPW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 1;
			bcd_q <= {adj[ND*4-2:0], sh_q[IPW-1]};
		end
	end

	generate
		if (ND > INT_DIGITS) begin : g_ovf
			assign ovf = |bcd_q[ND*4-1:INT_DIGITS*4];
		end else begin : g_no_ovf
			assign ovf = 1'b0;
		end
	endgenerate

	assign done   = done_q;
	assign digits = bcd_q[INT_DIGITS*4-1:0];

endmodule

>>> test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fpda_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	class decimal_text_board;
		text_char_t pending[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void note_number(logic signed [IN_W-1:0] value, logic [CFG_W-1:0] digits);
			logic [IN_W-1:0]            mag;
			logic [IN_W-1:0]            whole;
			logic [DEF_FRAC_BITS-1:0]   frac;
			logic [DEF_FRAC_BITS+3:0]   scaled;
			logic [3:0]                 dig [DEF_INT_DIGITS];
			logic [CHAR_W-1:0]          text [$];
			int                         nd;
			int                         nf;
			text_char_t                 c;
			mag = value[IN_W-1] ? -value : value;
			whole = mag >> DEF_FRAC_BITS;
			frac = mag[DEF_FRAC_BITS-1:0];
			nd = 0;
			if (whole == 0) begin
				dig[0] = 4'd0;
				nd = 1;
			end else begin
				while (whole != 0 && nd < DEF_INT_DIGITS) begin
					dig[nd] = 4'(whole % 10);
					whole = whole / 10;
					nd++;
				end
				if (whole != 0) begin
					for (int i = 0; i < DEF_INT_DIGITS; i++)
						dig[i] = 4'd9;
					nd = DEF_INT_DIGITS;
				end
			end
			if (value[IN_W-1])
				text.push_back(CH_MINUS);
			for (int i = nd - 1; i >= 0; i--)
				text.push_back(CH_ZERO + dig[i]);
			text.push_back(CH_POINT);
			nf = (digits > DEF_MAX_FRAC_DIGITS) ? DEF_MAX_FRAC_DIGITS : digits;
			for (int i = 0; i < nf; i++) begin
				scaled = frac * 10;
				text.push_back(CH_ZERO + scaled[DEF_FRAC_BITS+3:DEF_FRAC_BITS]);
				frac = scaled[DEF_FRAC_BITS-1:0];
			end
			foreach (text[i]) begin
				c.code = text[i];
				c.last = (i == text.size() - 1);
				pending.push_back(c);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] code, logic last);
			text_char_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected character 0x%h last=%0b", code, last);
				return;
			end
			want = pending.pop_front();
			if (want.code !== code || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("character mismatch: expected 0x%h last=%0b, got 0x%h last=%0b",
						want.code, want.last, code, last);
			end
		endfunction

		function int waiting();
			return pending.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [IN_W-1:0]  value_fixed;
	logic                    out_valid;
	logic                    out_ready;
	logic [CHAR_W-1:0]       char_code;
	logic                    last_char;
	logic                    cfg_we;
	logic [CFG_W-1:0]        cfg_wdata;

	decimal_text_board board;
	logic [CFG_W-1:0]  frac_digits_now;
	bit                in_gaps;
	bit                rx_gaps;
	int                rx_hold_len;

	fixed_point_to_decimal_ascii_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value_fixed (value_fixed),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_code   (char_code),
		.last_char   (last_char),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic signed [IN_W-1:0] to_fixed(longint whole, int frac, bit neg);
		longint                 raw;
		logic signed [IN_W-1:0] v;
		raw = (whole << DEF_FRAC_BITS) | longint'(frac);
		v = raw[IN_W-1:0];
		return neg ? -v : v;
	endfunction

	function automatic logic signed [IN_W-1:0] random_number();
		longint      p;
		longint      whole;
		int          frac;
		logic [63:0] wide;
		p = 1;
		case ($urandom_range(3))
			0: begin
				wide = {$urandom(), $urandom()};
				return wide[IN_W-1:0];
			end
			1: return to_fixed($urandom_range(999), $urandom_range(16'hFFFF), $urandom_range(1));
			2: begin
				repeat ($urandom_range(1, 9))
					p = p * 10;
				whole = p - $urandom_range(1);
				case ($urandom_range(2))
					0: frac = 0;
					1: frac = 16'hFFFF;
					default: frac = $urandom_range(16'hFFFF);
				endcase
				return to_fixed(whole, frac, $urandom_range(1));
			end
			default: return to_fixed(0, $urandom_range(16'hFFFF), $urandom_range(1));
		endcase
	endfunction

	task automatic send_number(input logic signed [IN_W-1:0] v);
		if (in_gaps && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		value_fixed <= v;
		do @(posedge clk); while (!in_ready);
		board.note_number(v, frac_digits_now);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_number(random_number());
	endtask

	task automatic wait_for_text(input int extra);
		in_valid <= 1'b0;
		while (board.waiting() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic set_frac_digits(input logic [CFG_W-1:0] digits);
		wait_for_text(8);
		cfg_we <= 1'b1;
		cfg_wdata <= digits;
		@(negedge clk);
		cfg_we <= 1'b0;
		frac_digits_now = digits;
	endtask

	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				hold = rx_hold_len;
				rx_hold_len = 0;
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end else if (rx_gaps && $urandom_range(99) < 10) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_char(char_code, last_char);
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_fixed = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_gaps = 1'b1;
		rx_gaps = 1'b1;
		rx_hold_len = 0;
		frac_digits_now = FRAC_DIGITS_RST;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_number(to_fixed(0, 0, 0));
		send_number(to_fixed(0, 1, 1));
		send_number(to_fixed(0, 1, 0));
		send_number(to_fixed(32'h7FFF_FFFF, 16'hFFFF, 0));
		send_number(to_fixed(longint'(1) << 31, 0, 1));
		send_number(to_fixed(1, 0, 0));
		send_number(to_fixed(1, 0, 1));
		send_number(to_fixed(0, 16'h8000, 1));
		send_number(to_fixed(0, 16'hFFFF, 0));
		send_number(to_fixed(9, 0, 0));
		send_number(to_fixed(10, 0, 0));
		send_number(to_fixed(99, 16'hFFFF, 1));
		send_number(to_fixed(1000000000, 0, 0));
		send_number(to_fixed(12345, 16'hA000, 0));

		set_frac_digits(4'd0);
		send_number(to_fixed(1, 16'h8000, 0));
		send_number(to_fixed(0, 16'h4000, 1));
		send_number(to_fixed(0, 0, 0));

		set_frac_digits(4'd15);
		send_number(to_fixed(0, 16'hFFFF, 0));
		send_number(to_fixed(longint'(1) << 31, 0, 1));
		send_number(to_fixed(0, 1, 0));
		send_random(40);

		set_frac_digits(4'd0);
		send_random(40);

		set_frac_digits(4'd8);
		in_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_random(50);
		wait_for_text(2);
		in_gaps = 1'b1;
		rx_gaps = 1'b1;

		set_frac_digits(4'd9);
		@(posedge clk);
		rx_hold_len = 300;
		@(negedge clk);
		send_random(50);

		set_frac_digits(4'd1);
		send_random(50);

		repeat (4) begin
			set_frac_digits(4'($urandom_range(15)));
			send_random(30);
		end

		wait_for_text(100);
		if (board.waiting() != 0) begin
			$display("%0d characters never arrived", board.waiting());
			board.mismatches++;
		end
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
